>>> rtl/d2d_pkg.sv
package d2d_pkg;

  // Columns at or beyond this width are not part of the image.
  localparam logic [31:0] MaxImageWidth = 32'd4096;

  localparam int unsigned PaddrW = 5;

  // Register index, taken from paddr[4:2]
  localparam logic [2:0] RegFocalBaseline = 3'd0;
  localparam logic [2:0] RegMinDepth      = 3'd1;
  localparam logic [2:0] RegMaxDepth      = 3'd2;
  localparam logic [2:0] RegFocalX        = 3'd3;
  localparam logic [2:0] RegFocalY        = 3'd4;
  localparam logic [2:0] RegCenterX       = 3'd5;
  localparam logic [2:0] RegCenterY       = 3'd6;
  localparam logic [2:0] RegColorize      = 3'd7;

  // Depth divider: {focal_baseline, 4'b0} / disparity, 20 quotient bits
  localparam int unsigned DepthNumW = 32;
  localparam int unsigned DepthDenW = 15;
  localparam int unsigned DepthQuoW = 20;

  // Projection dividers: |offset| * depth / focal, 31 quotient bits
  localparam int unsigned ProjNumW = 36;
  localparam int unsigned ProjDenW = 20;
  localparam int unsigned ProjQuoW = 31;

  typedef struct packed {
    logic signed [15:0] disparity_raw;
    logic [11:0]        pixel_col;
    logic [11:0]        pixel_row;
    logic [7:0]         blue_in;
    logic [7:0]         green_in;
    logic [7:0]         red_in;
    logic               has_color;
    logic               tex_masked;
  } d2d_in_t;

  typedef struct packed {
    logic [19:0]        depth_q4;
    logic               point_valid;
    logic signed [31:0] point_x_q4;
    logic signed [31:0] point_y_q4;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
  } d2d_out_t;

  // Carried alongside the depth divider
  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        has_color;
    logic        ok;
  } d2d_side_a_t;

  // Carried alongside the projection dividers
  typedef struct packed {
    logic [19:0] depth;
    logic        ok;
    logic        neg_x;
    logic        neg_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } d2d_side_b_t;

endpackage

>>> rtl/d2d_div.sv
module d2d_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 15,
  parameter int unsigned QW = 20,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned HW = NW - QW;

  logic [HW+DW-1:0] top_ext;
  logic [HW+DW-1:0] den_ext;

  logic          valid_q [QW+1];
  logic [DW-1:0] rem_q   [QW+1];
  logic [QW-1:0] low_q   [QW+1];
  logic [QW-1:0] quo_q   [QW+1];
  logic [DW-1:0] den_q   [QW+1];
  logic          ovf_q   [QW+1];
  logic [SW-1:0] side_q  [QW+1];

  // Quotient fits in QW bits exactly when the upper numerator bits stay below the divisor
  assign top_ext = {{DW{1'b0}}, num_i[NW-1:QW]};
  assign den_ext = {{HW{1'b0}}, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= top_ext[DW-1:0];
      low_q[0]  <= num_i[QW-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      ovf_q[0]  <= (top_ext >= den_ext);
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;
    logic [DW-1:0] rem_d;

    always_comb begin
      trial = {rem_q[k-1], low_q[k-1][QW-1]};
      diff  = trial - {1'b0, den_q[k-1]};
      take  = (trial >= {1'b0, den_q[k-1]});
      rem_d = take ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        low_q[k]  <= low_q[k-1] << 1;
        quo_q[k]  <= {quo_q[k-1][QW-2:0], take};
        den_q[k]  <= den_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = valid_q[QW];
  assign quo_o   = quo_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign side_o  = side_q[QW];

endmodule

>>> rtl/disparity_to_depth_point.sv
// Throughput: one pixel per cycle while the output is not stalled; the pipeline is
// one restoring-divider stage per quotient bit (20 for depth, 31 for each projection
// axis) plus six data stages.
// A stalled output beat holds the whole pipeline; input stall follows output stall.
// Reset clears all valid bits and loads the configuration register defaults.
module disparity_to_depth_point (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  d2d_pkg::d2d_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output d2d_pkg::d2d_out_t         out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [d2d_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  import d2d_pkg::*;

  // Configuration
  logic [27:0] focal_baseline_q;
  logic [19:0] min_depth_q;
  logic [19:0] max_depth_q;
  logic [19:0] focal_x_q;
  logic [19:0] focal_y_q;
  logic [15:0] center_x_q;
  logic [15:0] center_y_q;
  logic        colorize_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  logic advance;

  // Input stage
  logic        a_valid_q;
  d2d_in_t     a_data_q;
  logic        a_ok;
  d2d_side_a_t a_side;

  // Depth divider output
  logic                 dv_valid;
  logic [DepthQuoW-1:0] dv_quo;
  logic                 dv_ovf;
  d2d_side_a_t          dv_side;
  logic [$bits(d2d_side_a_t)-1:0] dv_side_bits;

  // Range check and offsets
  logic        b_valid_q;
  d2d_side_b_t b_side_d, b_side_q;
  logic [15:0] b_mag_x_d, b_mag_x_q;
  logic [15:0] b_mag_y_d, b_mag_y_q;
  logic [16:0] off_x;
  logic [16:0] off_y;
  logic        use_color;

  // Products
  logic                c_valid_q;
  d2d_side_b_t         c_side_q;
  logic [ProjNumW-1:0] c_prod_x_q;
  logic [ProjNumW-1:0] c_prod_y_q;
  logic [ProjDenW-1:0] fx_eff;
  logic [ProjDenW-1:0] fy_eff;

  // Projection divider outputs
  logic                px_valid, py_valid;
  logic [ProjQuoW-1:0] px_quo, py_quo;
  logic                px_ovf, py_ovf;
  d2d_side_b_t         px_side;
  logic [$bits(d2d_side_b_t)-1:0] px_side_bits;
  logic                py_neg;

  // Output stage
  logic     out_valid_q;
  d2d_out_t out_data_d, out_data_q;
  logic [31:0] x_val, y_val;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_baseline_q <= 28'd0;
      min_depth_q      <= 20'd0;
      max_depth_q      <= 20'hFFFFF;
      focal_x_q        <= 20'd16;
      focal_y_q        <= 20'd16;
      center_x_q       <= 16'd0;
      center_y_q       <= 16'd0;
      colorize_q       <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegFocalBaseline: focal_baseline_q <= pwdata[27:0];
        RegMinDepth:      min_depth_q      <= pwdata[19:0];
        RegMaxDepth:      max_depth_q      <= pwdata[19:0];
        RegFocalX:        focal_x_q        <= pwdata[19:0];
        RegFocalY:        focal_y_q        <= pwdata[19:0];
        RegCenterX:       center_x_q       <= pwdata[15:0];
        RegCenterY:       center_y_q       <= pwdata[15:0];
        RegColorize:      colorize_q       <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegFocalBaseline: prdata = {4'd0, focal_baseline_q};
      RegMinDepth:      prdata = {12'd0, min_depth_q};
      RegMaxDepth:      prdata = {12'd0, max_depth_q};
      RegFocalX:        prdata = {12'd0, focal_x_q};
      RegFocalY:        prdata = {12'd0, focal_y_q};
      RegCenterX:       prdata = {16'd0, center_x_q};
      RegCenterY:       prdata = {16'd0, center_y_q};
      RegColorize:      prdata = {31'd0, colorize_q};
    endcase
  end

  // ---------------------------------------------------------------- flow control
  // Advance everything unless the output beat is stuck.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;

  // ---------------------------------------------------------------- input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (advance) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_data_q <= in_data_i;
    end
  end

  always_comb begin
    a_ok = !a_data_q.disparity_raw[15] && (a_data_q.disparity_raw != 16'sd0) &&
           !a_data_q.tex_masked && ({20'd0, a_data_q.pixel_col} < MaxImageWidth);
    a_side.col       = a_data_q.pixel_col;
    a_side.row       = a_data_q.pixel_row;
    a_side.red       = a_data_q.red_in;
    a_side.green     = a_data_q.green_in;
    a_side.blue      = a_data_q.blue_in;
    a_side.has_color = a_data_q.has_color;
    a_side.ok        = a_ok;
  end

  d2d_div #(
    .NW(DepthNumW),
    .DW(DepthDenW),
    .QW(DepthQuoW),
    .SW($bits(d2d_side_a_t))
  ) u_depth_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (a_valid_q),
    .num_i   ({focal_baseline_q, 4'd0}),
    .den_i   (a_data_q.disparity_raw[14:0]),
    .side_i  (a_side),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .ovf_o   (dv_ovf),
    .side_o  (dv_side_bits)
  );

  assign dv_side = d2d_side_a_t'(dv_side_bits);

  // ---------------------------------------------------------------- range check
  always_comb begin
    off_x     = {1'b0, dv_side.col, 4'd0} - {1'b0, center_x_q};
    off_y     = {1'b0, dv_side.row, 4'd0} - {1'b0, center_y_q};
    b_mag_x_d = off_x[16] ? 16'(-off_x) : off_x[15:0];
    b_mag_y_d = off_y[16] ? 16'(-off_y) : off_y[15:0];
    use_color = colorize_q && dv_side.has_color;

    b_side_d.depth = dv_quo;
    b_side_d.ok    = dv_side.ok && !dv_ovf && (dv_quo >= min_depth_q) &&
                     (dv_quo <= max_depth_q);
    b_side_d.neg_x = off_x[16];
    b_side_d.neg_y = off_y[16];
    b_side_d.red   = use_color ? dv_side.red   : 8'hFF;
    b_side_d.green = use_color ? dv_side.green : 8'hFF;
    b_side_d.blue  = use_color ? dv_side.blue  : 8'hFF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (advance) begin
      b_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      b_side_q  <= b_side_d;
      b_mag_x_q <= b_mag_x_d;
      b_mag_y_q <= b_mag_y_d;
    end
  end

  // ---------------------------------------------------------------- multiply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (advance) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      c_side_q   <= b_side_q;
      c_prod_x_q <= ProjNumW'(b_mag_x_q) * ProjNumW'(b_side_q.depth);
      c_prod_y_q <= ProjNumW'(b_mag_y_q) * ProjNumW'(b_side_q.depth);
    end
  end

  // Zero focal length divides by one.
  assign fx_eff = (focal_x_q == '0) ? ProjDenW'(1) : focal_x_q;
  assign fy_eff = (focal_y_q == '0) ? ProjDenW'(1) : focal_y_q;

  d2d_div #(
    .NW(ProjNumW),
    .DW(ProjDenW),
    .QW(ProjQuoW),
    .SW($bits(d2d_side_b_t))
  ) u_x_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (c_valid_q),
    .num_i   (c_prod_x_q),
    .den_i   (fx_eff),
    .side_i  (c_side_q),
    .valid_o (px_valid),
    .quo_o   (px_quo),
    .ovf_o   (px_ovf),
    .side_o  (px_side_bits)
  );

  d2d_div #(
    .NW(ProjNumW),
    .DW(ProjDenW),
    .QW(ProjQuoW),
    .SW(1)
  ) u_y_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (c_valid_q),
    .num_i   (c_prod_y_q),
    .den_i   (fy_eff),
    .side_i  (c_side_q.neg_y),
    .valid_o (py_valid),
    .quo_o   (py_quo),
    .ovf_o   (py_ovf),
    .side_o  (py_neg)
  );

  assign px_side = d2d_side_b_t'(px_side_bits);

  // ---------------------------------------------------------------- sign, saturate
  always_comb begin
    if (px_ovf) begin
      x_val = px_side.neg_x ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      x_val = px_side.neg_x ? -{1'b0, px_quo} : {1'b0, px_quo};
    end
    if (py_ovf) begin
      y_val = py_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      y_val = py_neg ? -{1'b0, py_quo} : {1'b0, py_quo};
    end

    if (px_side.ok) begin
      out_data_d.depth_q4    = px_side.depth;
      out_data_d.point_valid = 1'b1;
      out_data_d.point_x_q4  = x_val;
      out_data_d.point_y_q4  = y_val;
      out_data_d.red_out     = px_side.red;
      out_data_d.green_out   = px_side.green;
      out_data_d.blue_out    = px_side.blue;
    end else begin
      out_data_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= px_valid && py_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
